// ===== design/vcrs_pkg.sv =====
// Shared types, constants and a helper function for the voxel cube region shifter.
`default_nettype none

package vcrs_pkg;

  localparam int unsigned CubeSide = 8;
  localparam int unsigned TopIndex = CubeSide - 1;
  localparam int unsigned SideW    = $clog2(CubeSide);
  localparam int unsigned FieldW   = 3;
  localparam int unsigned ByteW    = 8;

  typedef logic [CubeSide-1:0] word_t;

  typedef enum logic [2:0] {
    OpWrite = 3'd0,
    OpRead  = 3'd1,
    OpZFwd  = 3'd2,
    OpZRev  = 3'd3,
    OpYFwd  = 3'd4,
    OpYRev  = 3'd5,
    OpXFwd  = 3'd6,
    OpXRev  = 3'd7
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [FieldW-1:0] one_first;
    logic [FieldW-1:0] one_last;
    logic [FieldW-1:0] two_first;
    logic [FieldW-1:0] two_last;
    logic [FieldW-1:0] plane;
    logic [FieldW-1:0] row;
    logic [ByteW-1:0]  data;
  } cmd_t;

  // Selection mask for an inclusive range; indices beyond the cube fall away,
  // and a start above its end leaves the mask empty.
  function automatic word_t span_mask(logic [FieldW-1:0] first, logic [FieldW-1:0] last);
    word_t m;
    for (int i = 0; i < CubeSide; i++) begin
      m[i] = (i >= int'(first)) && (i <= int'(last));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/vcrs_in_stage.sv =====
// Input register of the shifter: holds one accepted word until it is applied.
`default_nettype none

module vcrs_in_stage import vcrs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire cmd_t cmd_i,
  input  wire logic advance_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cmd_q <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

`default_nettype wire

// ===== design/vcrs_store.sv =====
// Voxel store with its write, read and box shift logic.
`default_nettype none

module vcrs_store import vcrs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             apply_i,
  input  wire cmd_t             cmd_i,
  output logic      [ByteW-1:0] read_byte_o
);

  word_t store_q [CubeSide][CubeSide];
  word_t store_d [CubeSide][CubeSide];

  word_t            mask_one;
  word_t            mask_two;
  logic             addr_ok;
  logic [SideW-1:0] plane_idx;
  logic [SideW-1:0] row_idx;

  assign mask_one  = span_mask(cmd_i.one_first, cmd_i.one_last);
  assign mask_two  = span_mask(cmd_i.two_first, cmd_i.two_last);
  assign addr_ok   = (int'(cmd_i.plane) <= TopIndex) && (int'(cmd_i.row) <= TopIndex);
  assign plane_idx = cmd_i.plane[SideW-1:0];
  assign row_idx   = cmd_i.row[SideW-1:0];

  always_comb begin
    word_t src;
    src     = '0;
    store_d = store_q;
    unique case (cmd_i.op) inside
      OpWrite: begin
        if (addr_ok) begin
          store_d[plane_idx][row_idx] = word_t'(cmd_i.data);
        end
      end
      OpRead: begin
      end
      OpZFwd, OpZRev: begin
        for (int p = 0; p < CubeSide; p++) begin
          for (int r = 0; r < CubeSide; r++) begin
            if (mask_one[p] && mask_two[r]) begin
              store_d[p][r] = (cmd_i.op == OpZFwd) ? (store_q[p][r] << 1)
                                                   : (store_q[p][r] >> 1);
            end
          end
        end
      end
      OpYFwd, OpYRev: begin
        // Selected bits of each selected row move one plane; those bits of the vacated plane are cleared.
        for (int p = 0; p < CubeSide; p++) begin
          for (int r = 0; r < CubeSide; r++) begin
            if (cmd_i.op == OpYFwd) begin
              src = (p == 0) ? '0 : store_q[(p == 0) ? 0 : p - 1][r];
            end else begin
              src = (p == TopIndex) ? '0 : store_q[(p == TopIndex) ? p : p + 1][r];
            end
            if (mask_one[r]) begin
              store_d[p][r] = (store_q[p][r] & ~mask_two) | (src & mask_two);
            end
          end
        end
      end
      OpXFwd, OpXRev: begin
        for (int p = 0; p < CubeSide; p++) begin
          for (int r = 0; r < CubeSide; r++) begin
            if (cmd_i.op == OpXFwd) begin
              src = (r == 0) ? '0 : store_q[p][(r == 0) ? 0 : r - 1];
            end else begin
              src = (r == TopIndex) ? '0 : store_q[p][(r == TopIndex) ? r : r + 1];
            end
            if (mask_two[p]) begin
              store_d[p][r] = (store_q[p][r] & ~mask_one) | (src & mask_one);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < CubeSide; p++) begin
        for (int r = 0; r < CubeSide; r++) begin
          store_q[p][r] <= '0;
        end
      end
    end else if (apply_i) begin
      store_q <= store_d;
    end
  end

  // The read sees every earlier word, as those were applied in earlier cycles.
  assign read_byte_o = (cmd_i.op == OpRead && addr_ok) ? ByteW'(store_q[plane_idx][row_idx])
                                                       : '0;

endmodule

`default_nettype wire

// ===== design/voxel_cube_region_shift.sv =====
// A word accepted into the input register is applied as it moves to the result
// register. Throughput: one word per cycle unless the result side stalls; every
// operation completes in a single pass through the store update logic between
// the input and result registers. The input accepts a new word while a result
// waits, as long as the result register drains or the input register is empty.
// Reset clears both handshake stages and the whole cube to zero.
`default_nettype none

module voxel_cube_region_shift import vcrs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FieldW-1:0] opcode_i,
  input  wire logic [FieldW-1:0] range_one_first_i,
  input  wire logic [FieldW-1:0] range_one_last_i,
  input  wire logic [FieldW-1:0] range_two_first_i,
  input  wire logic [FieldW-1:0] range_two_last_i,
  input  wire logic [FieldW-1:0] plane_index_i,
  input  wire logic [FieldW-1:0] row_index_i,
  input  wire logic [ByteW-1:0]  write_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [ByteW-1:0]  read_byte_o
);

  cmd_t             cmd_in;
  cmd_t             cmd_held;
  logic             held_valid;
  logic             advance;
  logic [ByteW-1:0] rd_byte;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] read_byte_q;

  assign cmd_in = '{
    op:        op_e'(opcode_i),
    one_first: range_one_first_i,
    one_last:  range_one_last_i,
    two_first: range_two_first_i,
    two_last:  range_two_last_i,
    plane:     plane_index_i,
    row:       row_index_i,
    data:      write_byte_i
  };

  assign advance = held_valid && (!out_valid_q || out_ready_i);

  vcrs_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .cmd_i     (cmd_in),
    .advance_i (advance),
    .valid_o   (held_valid),
    .cmd_o     (cmd_held)
  );

  vcrs_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .apply_i     (advance),
    .cmd_i       (cmd_held),
    .read_byte_o (rd_byte)
  );

  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      read_byte_q <= rd_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = read_byte_q;

endmodule

`default_nettype wire

// ===== design/vcrs_checker.sv =====
// Port-level checks for the voxel cube region shifter, bound to the top level.
`default_nettype none

module vcrs_checker import vcrs_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [ByteW-1:0]  read_byte_o
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_byte_o))
    else $error("result word changed while stalled");

  // The input only stalls when both stages are occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with an empty result register");

  // A draining result always frees room for a new word.
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input not ready while the result drains");

  // Nothing is presented in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("pipeline not empty after reset");

endmodule

bind voxel_cube_region_shift vcrs_checker u_vcrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .read_byte_o (read_byte_o)
);

`default_nettype wire

// ===== tb/sv/voxel_cube_region_shift_tb.sv =====
// Self-checking testbench for the voxel cube region shifter, with a shadow cube scoreboard.
`default_nettype none

module voxel_cube_region_shift_tb;
  import vcrs_pkg::*;

  localparam int unsigned RandomWords   = 850;
  localparam int unsigned SteadyWords   = 120;
  localparam int unsigned HoldAtWord    = 300;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ReportLimit   = 10;

  // Shadow copy of the cube; every accepted word is applied to it and the byte
  // it should return is queued for the result side.
  class cube_shadow;
    word_t            cube[CubeSide*CubeSide];
    logic [ByteW-1:0] expected_bytes[$];
    int unsigned      failures;
    int unsigned      results_seen;

    function new();
      foreach (cube[i]) cube[i] = '0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function word_t bit_select(int lo, int hi);
      word_t m;
      for (int i = 0; i < CubeSide; i++) m[i] = (i >= lo) && (i <= hi);
      return m;
    endfunction

    function logic [ByteW-1:0] apply_word(cmd_t c);
      logic [ByteW-1:0] rd;
      word_t            m;
      int               lo1, hi1, lo2, hi2, at;
      bit               fwd, empty;
      rd    = '0;
      lo1   = int'(c.one_first);
      hi1   = int'(c.one_last);
      lo2   = int'(c.two_first);
      hi2   = int'(c.two_last);
      empty = (lo1 > hi1) || (lo2 > hi2);
      fwd   = (c.op == OpZFwd) || (c.op == OpYFwd) || (c.op == OpXFwd);
      at    = int'(c.plane) * CubeSide + int'(c.row);
      case (c.op)
        OpWrite: cube[at] = c.data;
        OpRead:  rd = cube[at];
        OpZFwd, OpZRev: begin
          if (!empty) begin
            for (int p = lo1; p <= hi1; p++) begin
              for (int r = lo2; r <= hi2; r++) begin
                if (fwd) cube[p*CubeSide+r] = cube[p*CubeSide+r] << 1;
                else     cube[p*CubeSide+r] = cube[p*CubeSide+r] >> 1;
              end
            end
          end
        end
        OpYFwd, OpYRev: begin
          if (!empty) begin
            m = bit_select(lo2, hi2);
            for (int r = lo1; r <= hi1; r++) begin
              if (fwd) begin
                for (int p = TopIndex; p > 0; p--)
                  cube[p*CubeSide+r] = (cube[p*CubeSide+r] & ~m) | (cube[(p-1)*CubeSide+r] & m);
                cube[r] &= ~m;
              end else begin
                for (int p = 0; p < TopIndex; p++)
                  cube[p*CubeSide+r] = (cube[p*CubeSide+r] & ~m) | (cube[(p+1)*CubeSide+r] & m);
                cube[TopIndex*CubeSide+r] &= ~m;
              end
            end
          end
        end
        default: begin
          if (!empty) begin
            m = bit_select(lo1, hi1);
            for (int p = lo2; p <= hi2; p++) begin
              if (fwd) begin
                for (int r = TopIndex; r > 0; r--)
                  cube[p*CubeSide+r] = (cube[p*CubeSide+r] & ~m) | (cube[p*CubeSide+r-1] & m);
                cube[p*CubeSide] &= ~m;
              end else begin
                for (int r = 0; r < TopIndex; r++)
                  cube[p*CubeSide+r] = (cube[p*CubeSide+r] & ~m) | (cube[p*CubeSide+r+1] & m);
                cube[p*CubeSide+TopIndex] &= ~m;
              end
            end
          end
        end
      endcase
      return rd;
    endfunction

    function void note_word(cmd_t c);
      expected_bytes.push_back(apply_word(c));
    endfunction

    function void check_read(logic [ByteW-1:0] got);
      logic [ByteW-1:0] want;
      results_seen++;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("result %0d arrived with nothing expected: read_byte=%02h",
                   results_seen, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= ReportLimit)
            $display("result %0d read_byte mismatch: expected %02h, got %02h",
                     results_seen, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_ready_o;
  logic [FieldW-1:0] opcode_i          = '0;
  logic [FieldW-1:0] range_one_first_i = '0;
  logic [FieldW-1:0] range_one_last_i  = '0;
  logic [FieldW-1:0] range_two_first_i = '0;
  logic [FieldW-1:0] range_two_last_i  = '0;
  logic [FieldW-1:0] plane_index_i     = '0;
  logic [FieldW-1:0] row_index_i       = '0;
  logic [ByteW-1:0]  write_byte_i      = '0;
  logic              out_valid_o;
  logic              out_ready_i       = 1'b0;
  logic [ByteW-1:0]  read_byte_o;

  cube_shadow  shadow = new();
  int unsigned words_sent = 0;
  bit          steady     = 1'b0;
  bit          hold_req   = 1'b0;

  voxel_cube_region_shift dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .range_one_first_i,
    .range_one_last_i,
    .range_two_first_i,
    .range_two_last_i,
    .plane_index_i,
    .row_index_i,
    .write_byte_i,
    .out_valid_o,
    .out_ready_i,
    .read_byte_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic cmd_t make_word(op_e op, int a0, int a1, int b0, int b1,
                                     int plane, int row, int data);
    cmd_t c;
    c.op        = op;
    c.one_first = a0[FieldW-1:0];
    c.one_last  = a1[FieldW-1:0];
    c.two_first = b0[FieldW-1:0];
    c.two_last  = b1[FieldW-1:0];
    c.plane     = plane[FieldW-1:0];
    c.row       = row[FieldW-1:0];
    c.data      = data[ByteW-1:0];
    return c;
  endfunction

  // Mostly ordered ranges so that shifts actually move voxels; a few are
  // drawn freely and may come out empty.
  function automatic cmd_t random_word();
    cmd_t        c;
    int unsigned pick, a0, b0;
    pick = $urandom_range(0, 99);
    if (pick < 30)      c.op = OpWrite;
    else if (pick < 55) c.op = OpRead;
    else                c.op = op_e'(FieldW'($urandom_range(OpZFwd, OpXRev)));
    if ($urandom_range(0, 4) == 0) begin
      c.one_first = FieldW'($urandom_range(0, TopIndex));
      c.one_last  = FieldW'($urandom_range(0, TopIndex));
      c.two_first = FieldW'($urandom_range(0, TopIndex));
      c.two_last  = FieldW'($urandom_range(0, TopIndex));
    end else begin
      a0 = $urandom_range(0, TopIndex);
      b0 = $urandom_range(0, TopIndex);
      c.one_first = FieldW'(a0);
      c.one_last  = FieldW'($urandom_range(a0, TopIndex));
      c.two_first = FieldW'(b0);
      c.two_last  = FieldW'($urandom_range(b0, TopIndex));
    end
    c.plane = FieldW'($urandom_range(0, TopIndex));
    c.row   = FieldW'($urandom_range(0, TopIndex));
    c.data  = ByteW'($urandom_range(0, 255));
    return c;
  endfunction

  // Offers one word, with a random gap ahead of it in the idling phases, and
  // returns once it has been taken.
  task automatic send_word(input cmd_t c);
    bool_gap: begin
      if (!steady && !hold_req && ((words_sent / 80) % 3 != 0)
          && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= c.op;
    range_one_first_i <= c.one_first;
    range_one_last_i  <= c.one_last;
    range_two_first_i <= c.two_first;
    range_two_last_i  <= c.two_last;
    plane_index_i     <= c.plane;
    row_index_i       <= c.row;
    write_byte_i      <= c.data;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_word(c);
    words_sent++;
  endtask

  // Result side: checks every word taken, stalls in random bursts, and holds
  // off once for a long stretch so that the block backs up into its input.
  initial begin
    int unsigned stall_left, hold_left, cycles;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    cycles     = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (out_valid_o && out_ready_i) shadow.check_read(read_byte_o);
      if (hold_req && !hold_done) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!steady && ((cycles / 500) % 3 != 1) && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: cleared cube, extreme corners, every shift over the whole
    // cube, empty ranges and single-voxel boxes.
    send_word(make_word(OpRead,  0, 0, 0, 0, 0, 0, 8'h00));
    send_word(make_word(OpWrite, 0, 0, 0, 0, 0, 0, 8'hFF));
    send_word(make_word(OpWrite, 0, 0, 0, 0, 7, 7, 8'hFF));
    send_word(make_word(OpWrite, 0, 0, 0, 0, 3, 4, 8'hA5));
    send_word(make_word(OpRead,  0, 0, 0, 0, 7, 7, 8'h00));
    send_word(make_word(OpZFwd,  0, 7, 0, 7, 0, 0, 8'h00));
    send_word(make_word(OpRead,  0, 0, 0, 0, 0, 0, 8'h00));
    send_word(make_word(OpZRev,  0, 7, 0, 7, 0, 0, 8'h00));
    send_word(make_word(OpYFwd,  0, 7, 0, 7, 0, 0, 8'h00));
    send_word(make_word(OpRead,  0, 0, 0, 0, 1, 0, 8'h00));
    send_word(make_word(OpYRev,  0, 7, 0, 7, 0, 0, 8'h00));
    send_word(make_word(OpXFwd,  0, 7, 0, 7, 0, 0, 8'h00));
    send_word(make_word(OpXRev,  0, 7, 0, 7, 0, 0, 8'h00));
    send_word(make_word(OpXFwd,  5, 2, 0, 7, 0, 0, 8'h00));
    send_word(make_word(OpYRev,  0, 7, 6, 1, 0, 0, 8'h00));
    send_word(make_word(OpZFwd,  3, 3, 4, 4, 0, 0, 8'h00));
    send_word(make_word(OpRead,  0, 0, 0, 0, 3, 4, 8'h00));
    send_word(make_word(OpYFwd,  4, 4, 0, 3, 0, 0, 8'h00));
    send_word(make_word(OpXRev,  4, 7, 7, 7, 0, 0, 8'h00));
    send_word(make_word(OpWrite, 0, 0, 0, 0, 7, 0, 8'h00));
    send_word(make_word(OpWrite, 0, 0, 0, 0, 0, 7, 8'h5A));
    send_word(make_word(OpRead,  0, 0, 0, 0, 4, 4, 8'h00));
    send_word(make_word(OpRead,  0, 0, 0, 0, 0, 7, 8'h00));

    for (int i = 0; i < RandomWords; i++) begin
      if (i == HoldAtWord) hold_req = 1'b1;
      if (i == HoldAtWord + 60) hold_req = 1'b0;
      if (i == RandomWords - SteadyWords) steady = 1'b1;
      send_word(random_word());
    end
    in_valid_i <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.failures == 0 && shadow.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/vcrs_pkg.sv
design/vcrs_in_stage.sv
design/vcrs_store.sv
design/voxel_cube_region_shift.sv
design/vcrs_checker.sv
tb/sv/voxel_cube_region_shift_tb.sv
